/* rtl/framed_command_led_controller_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the framed command LED controller
// Concurrent checks that stay out of builds that define NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef FRAMED_COMMAND_LED_CONTROLLER_ASSERT_SVH
`define FRAMED_COMMAND_LED_CONTROLLER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// ante must be followed by cons on the same clock edge
`define FCL_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// expr must never be true
`define FCL_ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`else

`define FCL_ASSERT_IMPL(label, ante, cons, msg)
`define FCL_ASSERT_NEVER(label, expr, msg)

`endif

`endif

/* rtl/fcl_pkg.sv */
// ----------------------------------------------------------------------------
// fcl_pkg
// Shared types, byte codes and sizes of the framed command LED controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fcl_pkg;

	localparam int NUM_LEDS   = 16;
	localparam int LED_IDX_W  = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
	localparam int NUM_PROTOS = 5;

	// frame bytes and command codes
	localparam logic [7:0] BYTE_START  = 8'h02;
	localparam logic [7:0] BYTE_END    = 8'h03;
	localparam logic [7:0] CMD_ALL_ON  = 8'h01;
	localparam logic [7:0] CMD_ALL_OFF = 8'h02;
	localparam logic [7:0] CMD_BRIGHT  = 8'h04;
	localparam logic [7:0] CMD_RED     = 8'h06;
	localparam logic [7:0] CMD_GREEN   = 8'h08;
	localparam logic [7:0] CMD_BLUE    = 8'h10;
	localparam logic [7:0] LEVEL_INIT  = 8'd128;

	typedef logic [2:0] proto_idx_t;
	localparam proto_idx_t P_RED   = 3'd0;
	localparam proto_idx_t P_GREEN = 3'd1;
	localparam proto_idx_t P_BLUE  = 3'd2;
	localparam proto_idx_t P_WHITE = 3'd3;
	localparam proto_idx_t P_SEL   = 3'd4;

	typedef struct packed {
		logic [7:0] g;
		logic [7:0] r;
		logic [7:0] b;
		logic [7:0] w;
	} pix_t;

	typedef enum logic [1:0] {
		ST_LED       = 2'd0,
		ST_END_ERR   = 2'd1,
		ST_BAD_INDEX = 2'd2,
		ST_BAD_CMD   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		PX_PASS,
		PX_LOAD,
		PX_ZERO,
		PX_SCALE,
		PX_REMAP
	} pix_op_t;

	typedef enum logic [2:0] {
		JOB_STATUS,
		JOB_ALL_ON,
		JOB_ALL_OFF,
		JOB_PAINT,
		JOB_BRIGHT
	} job_kind_t;

	// work handed from the frame decoder to the sequencer
	typedef struct packed {
		logic                 start;
		job_kind_t            kind;
		status_t              stat;
		proto_idx_t           which;
		logic [LED_IDX_W-1:0] target;
	} job_t;

endpackage

/* rtl/fcl_pix_unit.sv */
// ----------------------------------------------------------------------------
// fcl_pix_unit
// Shared colour word unit: pass, load, clear, brightness rescale, re-map.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcl_pix_unit (
	input  fcl_pkg::pix_op_t op,
	input  fcl_pkg::pix_t    word,
	input  fcl_pkg::pix_t    alt,
	input  logic [7:0]       level,
	input  fcl_pkg::pix_t    proto_r,
	input  fcl_pkg::pix_t    proto_g,
	input  fcl_pkg::pix_t    proto_b,
	input  fcl_pkg::pix_t    proto_w,
	output fcl_pkg::pix_t    result
);
	import fcl_pkg::*;

	pix_t scaled;
	pix_t mapped;

	always_comb begin
		scaled = word;
		if (word.r != 8'd0) scaled.r = level;
		if (word.g != 8'd0) scaled.g = level;
		if (word.b != 8'd0) scaled.b = level;
		if (word.w != 8'd0) scaled.w = level;

		// each test looks at what the previous one left
		mapped = word;
		if (mapped.r != 8'd0) mapped = proto_r;
		if (mapped.g != 8'd0) mapped = proto_g;
		if (mapped.b != 8'd0) mapped = proto_b;
		if (mapped.w != 8'd0) mapped = proto_w;

		unique case (op)
			PX_PASS:  result = word;
			PX_LOAD:  result = alt;
			PX_ZERO:  result = '0;
			PX_SCALE: result = scaled;
			PX_REMAP: result = mapped;
			default:  result = word;
		endcase
	end

endmodule

/* rtl/fcl_framer.sv */
// ----------------------------------------------------------------------------
// fcl_framer
// Frame decoder: start, command, argument, end byte; issues one job per frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcl_framer (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    rx_byte,
	output fcl_pkg::job_t job,
	output logic [7:0]    level
);
	import fcl_pkg::*;

	typedef enum logic [1:0] {
		PH_START,
		PH_CMD,
		PH_ARG,
		PH_END
	} phase_t;

	phase_t               phase_q;
	logic [7:0]           cmd_q;
	logic [LED_IDX_W-1:0] target_q;
	logic                 bad_q;
	logic [7:0]           level_q;
	logic                 is_colour;
	logic                 in_range;

	assign is_colour = (cmd_q == CMD_RED) || (cmd_q == CMD_GREEN) || (cmd_q == CMD_BLUE);
	assign in_range  = {1'b0, rx_byte} < 9'(NUM_LEDS);
	assign level     = level_q;

	always_comb begin
		job        = '0;
		job.kind   = JOB_STATUS;
		job.stat   = ST_LED;
		job.which  = P_RED;
		job.target = target_q;
		if (accept && phase_q == PH_END) begin
			job.start = 1'b1;
			if (rx_byte != BYTE_END) begin
				job.stat = ST_END_ERR;
			end else if (bad_q) begin
				job.stat = ST_BAD_INDEX;
			end else begin
				unique case (cmd_q)
					CMD_ALL_ON:  job.kind = JOB_ALL_ON;
					CMD_ALL_OFF: job.kind = JOB_ALL_OFF;
					CMD_BRIGHT:  job.kind = JOB_BRIGHT;
					CMD_RED: begin
						job.kind  = JOB_PAINT;
						job.which = P_RED;
					end
					CMD_GREEN: begin
						job.kind  = JOB_PAINT;
						job.which = P_GREEN;
					end
					CMD_BLUE: begin
						job.kind  = JOB_PAINT;
						job.which = P_BLUE;
					end
					default: job.stat = ST_BAD_CMD;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			cmd_q    <= 8'd0;
			target_q <= '0;
			bad_q    <= 1'b0;
			level_q  <= LEVEL_INIT;
		end else if (accept) begin
			unique case (phase_q)
				PH_START: begin
					if (rx_byte == BYTE_START) phase_q <= PH_CMD;
				end
				PH_CMD: begin
					cmd_q   <= rx_byte;
					phase_q <= PH_ARG;
				end
				PH_ARG: begin
					if (is_colour) begin
						if (in_range) begin
							target_q <= LED_IDX_W'(rx_byte);
							bad_q    <= 1'b0;
						end else begin
							bad_q <= 1'b1;
						end
					end else if (cmd_q == CMD_BRIGHT) begin
						level_q <= rx_byte;
					end
					phase_q <= PH_END;
				end
				PH_END: begin
					phase_q <= PH_START;
					if (rx_byte == BYTE_END) begin
						cmd_q <= 8'd0;
						if (bad_q) begin
							bad_q    <= 1'b0;
							target_q <= '0;
						end
					end
				end
			endcase
		end
	end

endmodule

/* rtl/fcl_seq.sv */
// ----------------------------------------------------------------------------
// fcl_seq
// Job sequencer: prototype rescale pass, LED store sweep, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "framed_command_led_controller_assert.svh"

module fcl_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  fcl_pkg::job_t    job,
	input  logic [7:0]       level,
	output logic             idle,
	output logic             out_valid,
	input  logic             out_ready,
	output fcl_pkg::status_t out_status,
	output logic [3:0]       out_num,
	output fcl_pkg::pix_t    out_pix,
	output logic             out_fin
);
	import fcl_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCALE,
		S_SWEEP,
		S_STAT
	} state_t;

	typedef enum logic [1:0] {
		SW_FILL,
		SW_ZERO,
		SW_PAINT,
		SW_REMAP
	} sweep_t;

	state_t               state_q;
	sweep_t               mode_q;
	logic [LED_IDX_W-1:0] idx_q;
	logic [LED_IDX_W-1:0] target_q;
	proto_idx_t           pidx_q;
	status_t              stat_q;
	logic                 any_lit_q;
	pix_t                 paint_q;
	pix_t                 store_q [NUM_LEDS];
	pix_t                 proto_q [NUM_PROTOS];

	logic                 out_valid_q;
	status_t              out_status_q;
	logic [3:0]           out_num_q;
	pix_t                 out_pix_q;
	logic                 out_fin_q;

	logic                 out_free;
	logic                 out_load;
	logic                 last_led;
	proto_idx_t           prd_idx;
	pix_t                 prd;
	pix_op_t              op;
	pix_t                 unit_in;
	pix_t                 unit_out;

	assign out_free = !out_valid_q || out_ready;
	// a new result goes into the output register this cycle
	assign out_load = out_free && (state_q == S_SWEEP || state_q == S_STAT);
	assign last_led = idx_q == LED_IDX_W'(NUM_LEDS - 1);
	// one prototype read port: job source when idle, rescale pointer otherwise
	assign prd_idx  = (state_q == S_IDLE) ? job.which : pidx_q;
	assign prd      = proto_q[prd_idx];
	assign unit_in  = (state_q == S_SCALE) ? prd : store_q[idx_q];

	always_comb begin
		op = PX_PASS;
		if (state_q == S_SCALE) begin
			op = PX_SCALE;
		end else begin
			unique case (mode_q)
				SW_FILL:  op = PX_LOAD;
				SW_ZERO:  op = PX_ZERO;
				SW_PAINT: op = (idx_q == target_q) ? PX_LOAD : PX_PASS;
				SW_REMAP: op = PX_REMAP;
			endcase
		end
	end

	fcl_pix_unit u_pix (
		.op      (op),
		.word    (unit_in),
		.alt     (paint_q),
		.level   (level),
		.proto_r (proto_q[P_RED]),
		.proto_g (proto_q[P_GREEN]),
		.proto_b (proto_q[P_BLUE]),
		.proto_w (proto_q[P_WHITE]),
		.result  (unit_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			mode_q       <= SW_FILL;
			idx_q        <= '0;
			target_q     <= '0;
			pidx_q       <= P_RED;
			stat_q       <= ST_LED;
			any_lit_q    <= 1'b0;
			paint_q      <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_LED;
			out_num_q    <= 4'd0;
			out_pix_q    <= '0;
			out_fin_q    <= 1'b0;
			for (int i = 0; i < NUM_LEDS; i++) store_q[i] <= '0;
			// word order g, r, b, w; selected colour starts as white
			proto_q[P_RED]   <= {8'd0, LEVEL_INIT, 8'd0, 8'd0};
			proto_q[P_GREEN] <= {LEVEL_INIT, 24'd0};
			proto_q[P_BLUE]  <= {16'd0, LEVEL_INIT, 8'd0};
			proto_q[P_WHITE] <= {24'd0, LEVEL_INIT};
			proto_q[P_SEL]   <= {24'd0, LEVEL_INIT};
		end else begin
			if (out_valid_q && out_ready && !out_load) out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (job.start) begin
						idx_q <= '0;
						unique case (job.kind)
							JOB_STATUS: begin
								stat_q  <= job.stat;
								state_q <= S_STAT;
							end
							JOB_ALL_ON: begin
								any_lit_q <= 1'b1;
								paint_q   <= proto_q[P_SEL];
								mode_q    <= SW_FILL;
								state_q   <= S_SWEEP;
							end
							JOB_ALL_OFF: begin
								any_lit_q <= 1'b0;
								mode_q    <= SW_ZERO;
								state_q   <= S_SWEEP;
							end
							JOB_PAINT: begin
								any_lit_q      <= 1'b1;
								paint_q        <= prd;
								proto_q[P_SEL] <= prd;
								target_q       <= job.target;
								mode_q         <= SW_PAINT;
								state_q        <= S_SWEEP;
							end
							JOB_BRIGHT: begin
								pidx_q  <= P_RED;
								state_q <= S_SCALE;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_SCALE: begin
					proto_q[pidx_q] <= unit_out;
					if (pidx_q == P_SEL) begin
						mode_q  <= SW_REMAP;
						state_q <= any_lit_q ? S_SWEEP : S_IDLE;
					end else begin
						pidx_q <= pidx_q + 3'd1;
					end
				end
				S_SWEEP: begin
					if (out_free) begin
						store_q[idx_q] <= unit_out;
						out_valid_q    <= 1'b1;
						out_status_q   <= ST_LED;
						out_num_q      <= 4'(idx_q);
						out_pix_q      <= unit_out;
						out_fin_q      <= last_led;
						if (last_led) begin
							state_q <= S_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				S_STAT: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= stat_q;
						out_num_q    <= 4'd0;
						out_pix_q    <= '0;
						out_fin_q    <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
			endcase
		end
	end

	assign idle       = state_q == S_IDLE;
	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_num    = out_num_q;
	assign out_pix    = out_pix_q;
	assign out_fin    = out_fin_q;

	`FCL_ASSERT_NEVER(a_scale_ptr, state_q == S_SCALE && pidx_q > P_SEL, "rescale pointer past prototypes")
	`FCL_ASSERT_NEVER(a_sweep_idx, state_q == S_SWEEP && idx_q > LED_IDX_W'(NUM_LEDS - 1), "sweep index out of range")
	`FCL_ASSERT_IMPL(a_status_item, out_valid_q && out_status_q != ST_LED, out_fin_q && out_pix_q == '0 && out_num_q == 4'd0, "status item not final or not blank")
	`FCL_ASSERT_IMPL(a_led_final, out_valid_q && out_status_q == ST_LED && out_fin_q, out_num_q == 4'(NUM_LEDS - 1), "refresh marked final early")

endmodule

/* rtl/framed_command_led_controller.sv */
// ----------------------------------------------------------------------------
// framed_command_led_controller
// Serial command frames in, refreshed RGBW LED words and status items out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Takes one received byte per transfer; frames are start 0x02, command,
// argument, end 0x03. The end byte hands a job to a sequencer that drives
// one shared colour word unit: a status job gives one item, a refresh walks
// the 16 LED words at one word per cycle while the output side does not
// stall, and a brightness command first rescales the five colour prototypes
// through the same unit, then re-maps the LEDs by a refresh if any LED is lit.
// in_ready is low while the sequencer works on a job. One output register
// holds the current result transfer, so the next byte can be taken while the
// last word still waits. Out-of-frame bytes are dropped; a bad end byte, bad
// LED index or unknown command each give one status item with zero colour
// fields and final_item set. A refresh marks its last LED word with
// final_item.

module framed_command_led_controller (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] status,
	output logic [3:0] led_number,
	output logic [7:0] chan_green,
	output logic [7:0] chan_red,
	output logic [7:0] chan_blue,
	output logic [7:0] chan_white,
	output logic       final_item
);
	import fcl_pkg::*;

	job_t       job;
	logic [7:0] level;
	logic       seq_idle;
	logic       in_xfer;
	status_t    out_status;
	pix_t       out_pix;

	// bytes are only taken while the sequencer has no job in hand
	assign in_ready = seq_idle;
	assign in_xfer  = in_valid && in_ready;

	fcl_framer u_framer (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (in_xfer),
		.rx_byte (rx_byte),
		.job     (job),
		.level   (level)
	);

	fcl_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.job        (job),
		.level      (level),
		.idle       (seq_idle),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_status (out_status),
		.out_num    (led_number),
		.out_pix    (out_pix),
		.out_fin    (final_item)
	);

	// word layout follows the strip order: green, red, blue, white
	assign status     = out_status;
	assign chan_green = out_pix.g;
	assign chan_red   = out_pix.r;
	assign chan_blue  = out_pix.b;
	assign chan_white = out_pix.w;

endmodule
